// ----- rtl/core/eurs_pkg.sv -----
// Package for the ultrasonic echo ranging sequencer.
// Holds the transaction types, the mode codes and the fixed-point constants
// for the distance conversion. It depends on nothing else.
`default_nettype none

package eurs_pkg;

    localparam int SENSOR_W    = 2;
    localparam int STAMP_IN_W  = 16;
    localparam int DIST_W      = 11;
    localparam int MAX_STAMP_W = 32;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 11'd150;

    // floor(width * 17 / 1000) equals (width * DIST_RECIP) >> DIST_SHIFT for
    // every width below SAT_WIDTH. At SAT_WIDTH and above the quotient is at
    // least 2048, which is more than any limit can be, so it saturates.
    localparam int MUL_IN_W = 17;
    localparam int RECIP_W  = 21;
    localparam int PROD_W   = MUL_IN_W + RECIP_W;
    localparam int DIST_SHIFT = 26;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1140851;
    localparam logic [MAX_STAMP_W-1:0] SAT_WIDTH = 32'd120471;

    typedef enum logic {
        MODE_CAPTURE = 1'b0,
        MODE_ARM     = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [SENSOR_W-1:0]   sensor;
        logic [STAMP_IN_W-1:0] stamp;
    } item_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_out;
        logic [DIST_W-1:0]   distance;
        logic                updated;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/eurs_distance.sv -----
// Pulse width and distance conversion for one echo.
// Uses the constants of eurs_pkg; purely combinational.
`default_nettype none

module eurs_distance #(
    parameter int STAMP_BITS = 16
) (
    input  logic [STAMP_BITS-1:0]      rise,
    input  logic [STAMP_BITS-1:0]      fall,
    input  logic [eurs_pkg::DIST_W-1:0] limit,
    output logic [eurs_pkg::DIST_W-1:0] dist_cm
);
    import eurs_pkg::*;

    logic [STAMP_BITS-1:0]  width;
    logic [MAX_STAMP_W-1:0] width_ext;
    logic [PROD_W-1:0]      prod;
    logic [DIST_W-1:0]      quot;

    always_comb begin
        // On a wrap the width is (M - rise) + fall, and M - rise is ~rise.
        if (fall > rise) begin
            width = fall - rise;
        end else if (rise > fall) begin
            width = fall + ~rise;
        end else begin
            width = '0;
        end
        width_ext = MAX_STAMP_W'(width);
        prod = PROD_W'(width_ext[MUL_IN_W-1:0]) * PROD_W'(DIST_RECIP);
        quot = prod[DIST_SHIFT +: DIST_W];
        if (width_ext >= SAT_WIDTH || quot > limit) begin
            dist_cm = limit;
        end else begin
            dist_cm = quot;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/eurs_tracker.sv -----
// Per-sensor measurement state, round-robin turn and the result of one item.
// Depends on eurs_pkg and eurs_distance.
`default_nettype none

module eurs_tracker #(
    parameter int NUM_SENSORS = 3,
    parameter int STAMP_BITS  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  eurs_pkg::item_t             item,
    input  logic [eurs_pkg::DIST_W-1:0] distance_limit,
    output eurs_pkg::result_t           result
);
    import eurs_pkg::*;

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic [NUM_SENSORS-1:0] high_seen_reg, high_seen_next;
    logic [NUM_SENSORS-1:0] armed_reg, armed_next;
    logic [STAMP_BITS-1:0]  rise_reg [NUM_SENSORS];
    logic [STAMP_BITS-1:0]  rise_next [NUM_SENSORS];
    logic [DIST_W-1:0]      dist_reg [NUM_SENSORS];
    logic [DIST_W-1:0]      dist_next [NUM_SENSORS];
    logic [IDX_W-1:0]       turn_reg, turn_next;

    logic [NUM_SENSORS-1:0] hit;
    logic                   in_range;
    logic                   cur_armed, cur_high;
    logic [STAMP_BITS-1:0]  cur_rise;
    logic [DIST_W-1:0]      cur_dist;
    logic [STAMP_BITS-1:0]  stamp_eff;
    logic [DIST_W-1:0]      new_dist;
    logic [SENSOR_W:0]      succ;
    logic                   is_turn, do_arm, do_rise, do_fall;

    assign stamp_eff = STAMP_BITS'(item.stamp);

    always_comb begin
        cur_armed = 1'b0;
        cur_high  = 1'b0;
        cur_rise  = '0;
        cur_dist  = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            hit[i]    = (item.sensor == SENSOR_W'(i));
            cur_armed = cur_armed | (armed_reg[i] & hit[i]);
            cur_high  = cur_high | (high_seen_reg[i] & hit[i]);
            cur_rise  = cur_rise | (rise_reg[i] & {STAMP_BITS{hit[i]}});
            cur_dist  = cur_dist | (dist_reg[i] & {DIST_W{hit[i]}});
        end
        in_range = |hit;
    end

    assign is_turn = (item.sensor == SENSOR_W'(turn_reg));
    assign do_arm  = in_range && (item.mode == MODE_ARM);
    assign do_rise = in_range && (item.mode == MODE_CAPTURE) && cur_armed && !cur_high
                     && is_turn;
    assign do_fall = in_range && (item.mode == MODE_CAPTURE) && cur_armed && cur_high;
    assign succ    = {1'b0, item.sensor} + 1'b1;

    eurs_distance #(
        .STAMP_BITS(STAMP_BITS)
    ) u_distance (
        .rise   (cur_rise),
        .fall   (stamp_eff),
        .limit  (distance_limit),
        .dist_cm(new_dist)
    );

    always_comb begin
        high_seen_next = high_seen_reg;
        armed_next     = armed_reg;
        turn_next      = turn_reg;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            rise_next[i] = rise_reg[i];
            dist_next[i] = dist_reg[i];
            if (fire && hit[i]) begin
                if (do_arm) begin
                    armed_next[i] = 1'b1;
                end
                if (do_rise) begin
                    rise_next[i]      = stamp_eff;
                    high_seen_next[i] = 1'b1;
                end
                if (do_fall) begin
                    dist_next[i]      = new_dist;
                    high_seen_next[i] = 1'b0;
                    armed_next[i]     = 1'b0;
                end
            end
        end
        if (fire && do_fall) begin
            turn_next = (succ >= (SENSOR_W + 1)'(NUM_SENSORS)) ? '0 : IDX_W'(succ);
        end
    end

    always_comb begin
        result.sensor_out = item.sensor;
        result.updated    = do_fall;
        if (!in_range) begin
            result.distance = '0;
        end else if (do_fall) begin
            result.distance = new_dist;
        end else begin
            result.distance = cur_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_seen_reg <= '0;
            armed_reg     <= '1;
            turn_reg      <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                rise_reg[i] <= '0;
                dist_reg[i] <= '0;
            end
        end else begin
            high_seen_reg <= high_seen_next;
            armed_reg     <= armed_next;
            turn_reg      <= turn_next;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                rise_reg[i] <= rise_next[i];
                dist_reg[i] <= dist_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_echo_ranging_sequencer.sv -----
// Top level of the ultrasonic echo ranging sequencer: input register, result
// register and distance_limit register around eurs_tracker.
// Depends on eurs_pkg and eurs_tracker.
`default_nettype none

// Each input transaction (a capture event or an arm request for one sensor)
// gives exactly one result transaction, via the input and result registers.
// One transaction is accepted in every cycle unless the result side stalls:
// the input register feeds an update of the per-sensor state, whose outcome
// lands in the result register, and while a result waits s_ready stays high
// only as long as the input register is empty. The stamp port is 16 bits wide
// and is taken modulo 2^STAMP_BITS. distance_limit resets to 150; the user
// must write it via cfg_wr_en/cfg_wr_data while idle, which is not enforced.

module ultrasonic_echo_ranging_sequencer #(
    parameter int NUM_SENSORS = 3,
    parameter int STAMP_BITS  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [eurs_pkg::DIST_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [eurs_pkg::SENSOR_W-1:0]   s_sensor,
    input  logic [eurs_pkg::STAMP_IN_W-1:0] s_stamp,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [eurs_pkg::SENSOR_W-1:0]   m_sensor_out,
    output logic [eurs_pkg::DIST_W-1:0]     m_distance,
    output logic                            m_updated
);
    import eurs_pkg::*;

    logic              item_valid_reg, item_valid_next;
    item_t             item_reg, item_next;
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg, out_next;
    logic [DIST_W-1:0] limit_reg, limit_next;
    result_t           result;
    logic              advance, fire, s_take;

    // The input register may move on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance = !m_valid_reg || m_ready;
    assign fire    = item_valid_reg && advance;
    assign s_ready = !item_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    eurs_tracker #(
        .NUM_SENSORS(NUM_SENSORS),
        .STAMP_BITS (STAMP_BITS)
    ) u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (item_reg),
        .distance_limit(limit_reg),
        .result        (result)
    );

    always_comb begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        if (advance) begin
            m_valid_next = item_valid_reg;
            out_next     = result;
        end
        if (s_ready) begin
            item_valid_next = s_valid;
        end
        if (s_take) begin
            item_next.mode   = mode_t'(s_mode);
            item_next.sensor = s_sensor;
            item_next.stamp  = s_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end else begin
            item_valid_reg <= item_valid_next;
            m_valid_reg    <= m_valid_next;
            limit_reg      <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sensor_out = out_reg.sensor_out;
    assign m_distance   = out_reg.distance;
    assign m_updated    = out_reg.updated;

`ifndef ASSERT_OFF
    a_updated_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.updated |-> out_reg.distance <= limit_reg)
        else $error("completed measurement above distance limit");

    a_out_of_range_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ({1'b0, out_reg.sensor_out} >= (SENSOR_W + 1)'(NUM_SENSORS))
        |-> out_reg.distance == '0 && !out_reg.updated)
        else $error("result for an absent sensor carries data");

    a_item_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("pending item lost while result side stalled");

    a_result_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(out_reg))
        else $error("waiting result changed before it was taken");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_ultrasonic_echo_ranging_sequencer.sv -----
// Testbench for ultrasonic_echo_ranging_sequencer: predicts every echo reading and
// checks the result channel against it under random source gaps and sink stalls.
// Depends on eurs_pkg and the sequencer RTL.

module tb_ultrasonic_echo_ranging_sequencer;
    import eurs_pkg::*;

    localparam int NUM_SENSORS = 3;
    localparam int STAMP_BITS = 16;
    localparam logic [STAMP_IN_W-1:0] STAMP_TOP = 16'hFFFF;
    localparam logic [DIST_W-1:0] LIMIT_FULL_RANGE = 11'd1114;
    localparam logic [DIST_W-1:0] LIMIT_ALL_ONES = 11'h7FF;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_RARE
    } ready_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [DIST_W-1:0]     cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic [SENSOR_W-1:0]   s_sensor;
    logic [STAMP_IN_W-1:0] s_stamp;
    logic                  m_valid;
    logic                  m_ready;
    logic [SENSOR_W-1:0]   m_sensor_out;
    logic [DIST_W-1:0]     m_distance;
    logic                  m_updated;

    // Predicted tracker state, kept in step with accepted transactions.
    logic                  rise_held     [NUM_SENSORS];
    logic [STAMP_IN_W-1:0] rise_time     [NUM_SENSORS];
    logic [DIST_W-1:0]     range_cm      [NUM_SENSORS];
    logic                  capture_armed [NUM_SENSORS];
    logic [SENSOR_W-1:0]   next_turn;
    logic [DIST_W-1:0]     limit_cm;

    result_t      pending_readings[$];
    int           err_count;
    int           items_sent;
    int           burst_left;
    int           stall_count;
    ready_style_t stall_style;

    ultrasonic_echo_ranging_sequencer #(
        .NUM_SENSORS(NUM_SENSORS),
        .STAMP_BITS (STAMP_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_sensor    (s_sensor),
        .s_stamp     (s_stamp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sensor_out(m_sensor_out),
        .m_distance  (m_distance),
        .m_updated   (m_updated)
    );

    always #4 aclk = ~aclk;

    function automatic result_t predict_echo(item_t it);
        result_t     r;
        int          s;
        int unsigned rise_u;
        int unsigned fall_u;
        int unsigned span;
        int unsigned cm;
        s = it.sensor;
        r.sensor_out = it.sensor;
        r.distance = '0;
        r.updated = 1'b0;
        if (s >= NUM_SENSORS) return r;
        if (it.mode == MODE_ARM) begin
            capture_armed[s] = 1'b1;
        end else if (capture_armed[s]) begin
            if (!rise_held[s]) begin
                if (next_turn == s) begin
                    rise_time[s] = it.stamp;
                    rise_held[s] = 1'b1;
                end
            end else begin
                rise_u = rise_time[s];
                fall_u = it.stamp;
                // A falling stamp below the rising one means the timer wrapped.
                if (fall_u > rise_u) span = fall_u - rise_u;
                else if (rise_u > fall_u) span = (STAMP_TOP - rise_u) + fall_u;
                else span = 0;
                cm = span * 17 / 1000;
                if (cm > limit_cm) cm = limit_cm;
                range_cm[s] = cm[DIST_W-1:0];
                rise_held[s] = 1'b0;
                capture_armed[s] = 1'b0;
                next_turn = (s + 1 >= NUM_SENSORS) ? '0 : SENSOR_W'(s + 1);
                r.updated = 1'b1;
            end
        end
        r.distance = range_cm[s];
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(mode_t mode, logic [SENSOR_W-1:0] sensor,
                             logic [STAMP_IN_W-1:0] stamp);
        item_t it;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        it.mode = mode;
        it.sensor = sensor;
        it.stamp = stamp;
        s_mode = mode;
        s_sensor = sensor;
        s_stamp = stamp;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_readings.push_back(predict_echo(it));
        items_sent++;
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic wait_readings_drained();
        s_valid = 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0) @(negedge aclk);
    endtask

    task automatic write_limit(logic [DIST_W-1:0] value);
        wait_readings_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        limit_cm = value;
    endtask

    // One well-formed measurement on the sensor whose turn it is, with optional
    // unrelated transactions between the rising and the falling edge.
    task automatic measure_turn_sensor(int noise);
        logic [SENSOR_W-1:0]   s;
        logic [SENSOR_W-1:0]   other;
        logic [STAMP_IN_W-1:0] rise_at;
        int                    w;
        s = next_turn;
        if (!capture_armed[s]) send_item(MODE_ARM, s, STAMP_IN_W'($urandom));
        if (rise_held[s]) begin
            rise_at = rise_time[s];
        end else begin
            rise_at = STAMP_IN_W'($urandom);
            send_item(MODE_CAPTURE, s, rise_at);
        end
        repeat (noise) begin
            other = SENSOR_W'($urandom_range(0, 3));
            if (other == s) send_item(MODE_ARM, other, STAMP_IN_W'($urandom));
            else send_item($urandom_range(0, 1) ? MODE_ARM : MODE_CAPTURE, other,
                           STAMP_IN_W'($urandom));
        end
        case ($urandom_range(0, 3))
            0, 1: w = int'($urandom_range(0, 7000));
            2: w = int'($urandom_range(0, 65535));
            default: begin
                w = int'(limit_cm) * 1000 / 17 + int'($urandom_range(0, 120)) - 60;
                if (w < 0) w = 0;
            end
        endcase
        send_item(MODE_CAPTURE, s, rise_at + STAMP_IN_W'(w));
    endtask

    task automatic full_span_measurement();
        logic [SENSOR_W-1:0] s;
        s = next_turn;
        send_item(MODE_ARM, s, 16'h0000);
        send_item(MODE_CAPTURE, s, 16'h0000);
        send_item(MODE_CAPTURE, s, STAMP_TOP);
    endtask

    task automatic test_directed_cases();
        send_item(MODE_CAPTURE, 2'd1, 16'h1234);   // not its turn
        send_item(MODE_CAPTURE, 2'd3, STAMP_TOP);  // no such sensor
        send_item(MODE_ARM, 2'd3, 16'h0000);
        send_item(MODE_CAPTURE, 2'd0, 16'h0000);
        send_item(MODE_CAPTURE, 2'd0, 16'h0000);   // equal stamps give zero
        send_item(MODE_CAPTURE, 2'd0, 16'h0FF0);   // disarmed
        send_item(MODE_ARM, 2'd0, 16'hFFFF);
        send_item(MODE_CAPTURE, 2'd1, STAMP_TOP);
        send_item(MODE_ARM, 2'd1, 16'h0001);       // rising edge must survive
        send_item(MODE_CAPTURE, 2'd1, 16'h0000);
        send_item(MODE_CAPTURE, 2'd2, 16'h0000);
        send_item(MODE_CAPTURE, 2'd2, STAMP_TOP);  // saturates, turn wraps
        send_item(MODE_CAPTURE, 2'd0, 16'd100);
        send_item(MODE_CAPTURE, 2'd2, 16'd5);
        send_item(MODE_CAPTURE, 2'd0, 16'd6000);
        send_item(MODE_ARM, 2'd1, 16'h8000);
        send_item(MODE_ARM, 2'd2, 16'h7FFF);
        send_item(MODE_CAPTURE, 2'd1, 16'd65000);
        send_item(MODE_CAPTURE, 2'd1, 16'd500);    // wrapped timer
        send_item(MODE_CAPTURE, 2'd2, 16'h5555);
        send_item(MODE_CAPTURE, 2'd2, 16'hAAAA);
    endtask

    task automatic test_limit_extremes();
        write_limit('0);
        full_span_measurement();
        write_limit(LIMIT_FULL_RANGE);
        full_span_measurement();
        write_limit(LIMIT_ALL_ONES);
        full_span_measurement();
    endtask

    task automatic test_random_traffic();
        logic [DIST_W-1:0] phase_limit [5];
        int                start;
        phase_limit = '{11'd0, LIMIT_FULL_RANGE, LIMIT_ALL_ONES, LIMIT_RESET, 11'd0};
        phase_limit[0] = DIST_W'($urandom_range(0, 1114));
        foreach (phase_limit[p]) begin
            write_limit(phase_limit[p]);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 7) begin
                    measure_turn_sensor($urandom_range(0, 2));
                end else begin
                    send_item($urandom_range(0, 1) ? MODE_ARM : MODE_CAPTURE,
                              SENSOR_W'($urandom_range(0, 3)), STAMP_IN_W'($urandom));
                end
            end
        end
    endtask

    always @(negedge aclk) begin
        if (stall_count == 0) begin
            stall_style = ready_style_t'($urandom_range(0, 3));
            stall_count = $urandom_range(16, 80);
        end
        stall_count--;
        case (stall_style)
            READY_ALWAYS: m_ready = 1'b1;
            READY_COIN: m_ready = 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: m_ready = (stall_count % 4 == 0);
            default: m_ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected transaction: sensor_out %0d distance %0d updated %0d",
                       m_sensor_out, m_distance, m_updated);
                err_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_sensor_out !== want.sensor_out) begin
                    $error("sensor_out: expected %0d, actual %0d", want.sensor_out, m_sensor_out);
                    err_count++;
                end
                if (m_distance !== want.distance) begin
                    $error("distance: expected %0d, actual %0d", want.distance, m_distance);
                    err_count++;
                end
                if (m_updated !== want.updated) begin
                    $error("updated: expected %0d, actual %0d", want.updated, m_updated);
                    err_count++;
                end
            end
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_mode = MODE_CAPTURE;
        s_sensor = '0;
        s_stamp = '0;
        m_ready = 1'b0;
        err_count = 0;
        items_sent = 0;
        burst_left = 0;
        stall_count = 0;
        stall_style = READY_ALWAYS;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            rise_held[i] = 1'b0;
            rise_time[i] = '0;
            range_cm[i] = '0;
            capture_armed[i] = 1'b1;
        end
        next_turn = '0;
        limit_cm = LIMIT_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_limit_extremes();
        test_random_traffic();

        wait_readings_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_ultrasonic_echo_ranging_sequencer: clean");
        end else begin
            $display("tb_ultrasonic_echo_ranging_sequencer: errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_ultrasonic_echo_ranging_sequencer: errors");
        $finish;
    end

endmodule
